// ===== src/cpf_pkg.sv =====
// Shared constants and types for the capture period to frequency meter.
// Used by capture_period_to_frequency, frequency_checker and tb_top; no other dependencies.
package cpf_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned SCALE_W   = 32;
   localparam int unsigned OFFSET_W  = 48;
   localparam int unsigned ID_W      = 16;
   localparam int unsigned FREQ_W    = 50;
   localparam int unsigned WIDE_W    = 64;
   localparam int unsigned QUOT_W    = 49;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 48;
   localparam int unsigned STEP_W    = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PUBLISH_EVERY = 2'd0,
      CSR_PERIOD_SCALE  = 2'd1,
      CSR_PERIOD_OFFSET = 2'd2,
      CSR_MESSAGE_ID    = 2'd3
   } csr_index_type;

   localparam logic [COUNT_W-1:0] PUBLISH_EVERY_RESET = 16'd1;
   localparam logic [SCALE_W-1:0] PERIOD_SCALE_RESET  = 32'h0001_0000;
   localparam logic [COUNT_W-1:0] COUNT_MAX           = 16'hFFFF;
   localparam logic [STEP_W-1:0]  MUL_LAST_STEP       = 6'd31;
   localparam logic [STEP_W-1:0]  DIV_FIRST_STEP      = 6'd48;

endpackage

// ===== src/capture_period_to_frequency.sv =====
// Top level of the capture period to frequency meter: period averaging, bit-serial
// scaling multiply, saturating offset and bit-serial reciprocal division.
// Depends on cpf_pkg.
//
// Each transfer on the req_ channel carries one capture timestamp. A timestamp that
// causes no result leaves the block idle and ready to take the next one. A timestamp
// that publishes a result holds off the next one while it passes through these steps
// in order: the update, a one-bit-per-cycle shift-add multiply, the saturating offset
// add, a restoring reciprocal division that yields one quotient bit per cycle, and
// the load of the output register, which waits while an earlier result is still
// stalled. The result waits in that register until the rsp_ transfer, while the next
// timestamp may already be taken.
module capture_period_to_frequency (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cpf_pkg::TIME_W-1:0]           req_capture_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cpf_pkg::ID_W-1:0]             rsp_out_id,
   output logic signed [cpf_pkg::FREQ_W-1:0]    rsp_frequency,
   input  logic                                 csr_write,
   input  logic [cpf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cpf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cpf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [TIME_W-1:0]    last_time_ff, last_time_in;
   logic [TIME_W-1:0]    average_ff, average_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   publish_every_ff, publish_every_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic [ID_W-1:0]      message_id_ff, message_id_in;
   logic [WIDE_W-1:0]    acc_ff, acc_in;
   logic [TIME_W-1:0]    mul_bits_ff, mul_bits_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [WIDE_W-1:0]    mag_ff, mag_in;
   logic [WIDE_W-1:0]    rem_ff, rem_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [FREQ_W-1:0]    rsp_freq_ff, rsp_freq_in;

   logic [TIME_W-1:0]    period;
   logic [TIME_W:0]      avg_sum;
   logic [COUNT_W-1:0]   count_next;
   logic [WIDE_W-1:0]    scale_ext;
   logic [WIDE_W-1:0]    offset_ext;
   logic [WIDE_W-1:0]    sum;
   logic [WIDE_W-1:0]    scaled;
   logic [WIDE_W:0]      trial;
   logic [WIDE_W:0]      diff;
   logic [FREQ_W-1:0]    quot_ext;
   logic                 req_take;
   logic                 rsp_take;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_take      = req_valid && !req_stall;
   assign rsp_take      = rsp_valid_ff && !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_id    = rsp_id_ff;
   assign rsp_frequency = rsp_freq_ff;

   assign period     = req_capture_time - last_time_ff;
   assign avg_sum    = {1'b0, average_ff} + {1'b0, period};
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign scale_ext  = {{(WIDE_W-SCALE_W){scale_ff[SCALE_W-1]}}, scale_ff};
   assign offset_ext = {{(WIDE_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};
   assign sum        = acc_ff + offset_ext;
   assign trial      = {rem_ff, (step_ff == DIV_FIRST_STEP)};
   assign diff       = trial - {1'b0, mag_ff};
   assign quot_ext   = {{(FREQ_W-QUOT_W){1'b0}}, quot_ff};

   always_comb begin
      if (acc_ff[WIDE_W-1] == offset_ext[WIDE_W-1] && sum[WIDE_W-1] != acc_ff[WIDE_W-1]) begin
         scaled = acc_ff[WIDE_W-1] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
      end else begin
         scaled = sum;
      end
   end

   always_comb begin
      state_in         = state_ff;
      last_time_in     = last_time_ff;
      average_in       = average_ff;
      count_in         = count_ff;
      publish_every_in = publish_every_ff;
      scale_in         = scale_ff;
      offset_in        = offset_ff;
      message_id_in    = message_id_ff;
      acc_in           = acc_ff;
      mul_bits_in      = mul_bits_ff;
      step_in          = step_ff;
      mag_in           = mag_ff;
      rem_in           = rem_ff;
      quot_in          = quot_ff;
      neg_in           = neg_ff;
      zero_in          = zero_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_id_in        = rsp_id_ff;
      rsp_freq_in      = rsp_freq_ff;

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_PUBLISH_EVERY: publish_every_in = csr_wdata[COUNT_W-1:0];
            CSR_PERIOD_SCALE:  scale_in         = csr_wdata[SCALE_W-1:0];
            CSR_PERIOD_OFFSET: offset_in        = csr_wdata[OFFSET_W-1:0];
            CSR_MESSAGE_ID:    message_id_in    = csr_wdata[ID_W-1:0];
            default: ;
         endcase
      end

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_time_in = req_capture_time;
               if (last_time_ff <= req_capture_time) begin
                  average_in = avg_sum[TIME_W:1];
                  if (count_next >= publish_every_ff) begin
                     count_in    = '0;
                     acc_in      = '0;
                     mul_bits_in = avg_sum[TIME_W:1];
                     step_in     = MUL_LAST_STEP;
                     state_in    = ST_MUL;
                  end else begin
                     count_in = count_next;
                  end
               end
            end
         end
         ST_MUL: begin
            acc_in      = {acc_ff[WIDE_W-2:0], 1'b0} + (mul_bits_ff[TIME_W-1] ? scale_ext : '0);
            mul_bits_in = {mul_bits_ff[TIME_W-2:0], 1'b0};
            step_in     = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            neg_in   = scaled[WIDE_W-1];
            mag_in   = scaled[WIDE_W-1] ? ('0 - scaled) : scaled;
            zero_in  = (scaled == '0);
            rem_in   = '0;
            quot_in  = '0;
            step_in  = DIV_FIRST_STEP;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!diff[WIDE_W]) begin
               rem_in  = diff[WIDE_W-1:0];
               quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[WIDE_W-1:0];
               quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = message_id_ff;
               if (zero_ff) begin
                  rsp_freq_in = '0;
               end else if (neg_ff) begin
                  rsp_freq_in = '0 - quot_ext;
               end else begin
                  rsp_freq_in = quot_ext;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         last_time_ff     <= '0;
         average_ff       <= '0;
         count_ff         <= '0;
         publish_every_ff <= PUBLISH_EVERY_RESET;
         scale_ff         <= PERIOD_SCALE_RESET;
         offset_ff        <= '0;
         message_id_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         last_time_ff     <= last_time_in;
         average_ff       <= average_in;
         count_ff         <= count_in;
         publish_every_ff <= publish_every_in;
         scale_ff         <= scale_in;
         offset_ff        <= offset_in;
         message_id_ff    <= message_id_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      mul_bits_ff <= mul_bits_in;
      step_ff     <= step_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_freq_ff <= rsp_freq_in;
   end

endmodule

// ===== tb/frequency_checker.sv =====
`timescale 1ns / 1ps
// Result checker for capture_period_to_frequency: tracks register writes and capture transfers,
// predicts every published frequency and compares it with the result transfers.
// Depends on cpf_pkg.
module frequency_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [cpf_pkg::TIME_W-1:0]          req_capture_time,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [cpf_pkg::ID_W-1:0]            rsp_out_id,
   input  logic signed [cpf_pkg::FREQ_W-1:0]   rsp_frequency,
   input  logic                                csr_write,
   input  logic [cpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  error_count,
   output int                                  readings_due
);
   import cpf_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [FREQ_W-1:0] freq;
   } reading_type;

   localparam longint SCALED_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SCALED_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [WIDE_W-1:0] RECIP_NUMERATOR = 64'h0001_0000_0000_0000;

   logic [COUNT_W-1:0]         publish_every;
   logic signed [SCALE_W-1:0]  period_scale;
   logic signed [OFFSET_W-1:0] period_offset;
   logic [ID_W-1:0]            message_id;

   logic [TIME_W-1:0]  last_time;
   logic [TIME_W-1:0]  average_period;
   logic [COUNT_W-1:0] period_count;

   reading_type expected_readings[$];
   int          mismatches = 0;

   function automatic logic [FREQ_W-1:0] reciprocal(input longint scaled);
      logic [WIDE_W-1:0] mag;
      logic [WIDE_W-1:0] quot;
      if (scaled == 0) return '0;
      mag = scaled;
      if (scaled < 0) mag = ~mag + 1'b1;
      quot = RECIP_NUMERATOR / mag;
      if (scaled < 0) quot = ~quot + 1'b1;
      return quot[FREQ_W-1:0];
   endfunction

   function automatic bit take_capture(input logic [TIME_W-1:0] now,
                                       output reading_type reading);
      logic [TIME_W-1:0] period;
      logic [TIME_W:0]   total;
      longint            prod;
      longint            offs;
      longint            scaled;
      reading = '0;
      if (last_time > now) begin
         last_time = now;
         return 1'b0;
      end
      period = now - last_time;
      last_time = now;
      total = {1'b0, average_period} + {1'b0, period};
      average_period = total[TIME_W:1];
      if (period_count != COUNT_MAX) period_count = period_count + 1'b1;
      if (period_count < publish_every) return 1'b0;
      prod = $signed({{(WIDE_W-TIME_W){1'b0}}, average_period}) * longint'(period_scale);
      offs = longint'(period_offset);
      if (offs > 0 && prod > SCALED_MAX - offs) begin
         scaled = SCALED_MAX;
      end else if (offs < 0 && prod < SCALED_MIN - offs) begin
         scaled = SCALED_MIN;
      end else begin
         scaled = prod + offs;
      end
      reading.id = message_id;
      reading.freq = reciprocal(scaled);
      period_count = '0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         publish_every = PUBLISH_EVERY_RESET;
         period_scale = PERIOD_SCALE_RESET;
         period_offset = '0;
         message_id = '0;
         last_time = '0;
         average_period = '0;
         period_count = '0;
         expected_readings.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_PUBLISH_EVERY: publish_every = csr_wdata[COUNT_W-1:0];
               CSR_PERIOD_SCALE:  period_scale = csr_wdata[SCALE_W-1:0];
               CSR_PERIOD_OFFSET: period_offset = csr_wdata[OFFSET_W-1:0];
               CSR_MESSAGE_ID:    message_id = csr_wdata[ID_W-1:0];
            endcase
         end
         if (req_valid && !req_stall) begin
            if (take_capture(req_capture_time, want)) expected_readings.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               $error("unexpected result transfer: out_id %0h, frequency %0h",
                      rsp_out_id, rsp_frequency);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_out_id !== want.id) begin
                  mismatches++;
                  $error("out_id mismatch: expected %0h, actual %0h", want.id, rsp_out_id);
               end
               if (rsp_frequency !== want.freq) begin
                  mismatches++;
                  $error("frequency mismatch: expected %0h, actual %0h",
                         want.freq, rsp_frequency);
               end
            end
         end
      end
      error_count <= mismatches;
      readings_due <= expected_readings.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the capture_period_to_frequency testbench: clock, reset, register writes and capture
// stimulus with random idling on both channels; frequency_checker judges the results.
// Depends on cpf_pkg, capture_period_to_frequency and frequency_checker.
module tb_top;
   import cpf_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam int LONG_ITEMS    = 60;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [TIME_W-1:0]         req_capture_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [ID_W-1:0]           rsp_out_id;
   logic signed [FREQ_W-1:0]  rsp_frequency;
   logic                      csr_write = 1'b0;
   csr_index_type             csr_index = CSR_PUBLISH_EVERY;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int                error_count;
   int                readings_due;
   int                cycles = 0;
   int                stall_left = 0;
   bit                sender_idles = 1'b0;
   bit                receiver_stalls = 1'b0;
   logic [TIME_W-1:0] last_stamp = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   capture_period_to_frequency dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_capture_time (req_capture_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_id       (rsp_out_id),
      .rsp_frequency    (rsp_frequency),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   frequency_checker u_freq_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_capture_time (req_capture_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_id       (rsp_out_id),
      .rsp_frequency    (rsp_frequency),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .readings_due     (readings_due)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!receiver_stalls) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Unused upper data bits carry random values; the block keeps only the register width.
   task automatic write_meter(input logic [COUNT_W-1:0] every, input logic [SCALE_W-1:0] scale,
                              input logic [OFFSET_W-1:0] offset, input logic [ID_W-1:0] id);
      write_reg(CSR_PUBLISH_EVERY, {32'($urandom), every});
      write_reg(CSR_PERIOD_SCALE, {16'($urandom), scale});
      write_reg(CSR_PERIOD_OFFSET, offset);
      write_reg(CSR_MESSAGE_ID, {32'($urandom), id});
   endtask

   task automatic send_stamp(input logic [TIME_W-1:0] stamp);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_capture_time <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_stamp = stamp;
   endtask

   // Waits until every published frequency has arrived and the block has gone quiet.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [TIME_W-1:0] pick_stamp(input bit steady);
      int unsigned       r;
      logic [TIME_W-1:0] delta;
      r = $urandom_range(0, 99);
      if (steady) begin
         if (r < 3) return (last_stamp == 0) ? $urandom : $urandom_range(0, last_stamp - 1);
         return last_stamp + $urandom_range(0, 255);
      end
      if (r < 70) begin
         case ($urandom_range(0, 3))
            0:       delta = $urandom_range(0, 15);
            1:       delta = $urandom_range(0, 16'hFFFF);
            2:       delta = $urandom_range(0, 24'hFF_FFFF);
            default: delta = $urandom;
         endcase
         return last_stamp + delta;
      end
      if (r < 80) return last_stamp;
      if (r < 90) return (last_stamp == 0) ? '0 : $urandom_range(0, last_stamp - 1);
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_setting();
      logic [COUNT_W-1:0]  every;
      logic [SCALE_W-1:0]  scale;
      logic [OFFSET_W-1:0] offset;
      case ($urandom_range(0, 5))
         0:       every = '0;
         1:       every = 16'd1;
         2, 3:    every = 16'($urandom_range(2, 4));
         4:       every = 16'($urandom_range(5, 12));
         default: every = 16'd1;
      endcase
      case ($urandom_range(0, 5))
         0:       scale = 32'h8000_0000;
         1:       scale = 32'h7FFF_FFFF;
         2:       scale = '0;
         3:       scale = 32'h0001_0000;
         4:       scale = $urandom;
         default: scale = $urandom_range(0, 32'h0004_0000);
      endcase
      case ($urandom_range(0, 4))
         0:       offset = 48'h8000_0000_0000;
         1:       offset = 48'h7FFF_FFFF_FFFF;
         2:       offset = '0;
         3:       offset = {16'($urandom), 32'($urandom)};
         default: offset = 48'($urandom_range(0, 2000)) - 48'd1000;
      endcase
      write_meter(every, scale, offset, 16'($urandom));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: equal stamp, normal periods, a full-range period and a stamp going back.
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      send_stamp(0);
      send_stamp(1000);
      send_stamp('1);
      send_stamp(7);
      send_stamp(7);
      send_stamp('1);
      settle();

      // Publish on every period, a scaled value of one, then of minus one, then zero.
      write_meter(16'd0, 32'd0, 48'd1, 16'hFFFF);
      send_stamp(0);
      send_stamp(10);
      settle();
      write_reg(CSR_PERIOD_OFFSET, '1);
      send_stamp(20);
      settle();
      write_reg(CSR_PERIOD_OFFSET, '0);
      send_stamp(20);
      send_stamp(21);
      settle();

      write_meter(16'd3, 32'h0001_0000, 48'd0, 16'h1234);
      repeat (7) send_stamp(last_stamp + $urandom_range(0, 40));
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_setting();
         sender_idles = (p % 3 != 2);
         receiver_stalls = (p % 3 != 1);
         repeat (PHASE_ITEMS) send_stamp(pick_stamp(1'b0));
         settle();
      end

      // Full-range periods push the average to the top so the offset add saturates both ways.
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      write_meter(16'd1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 16'h0000);
      repeat (20) begin
         send_stamp(0);
         send_stamp('1);
      end
      settle();
      write_meter(16'd1, 32'h8000_0000, 48'h8000_0000_0000, 16'hA5A5);
      repeat (3) begin
         send_stamp(0);
         send_stamp('1);
      end
      settle();

      // Steady stamps with frequent results, run without idling on either side.
      write_meter(16'($urandom_range(0, 2)), $urandom_range(1, 32'h0002_0000), 48'($urandom),
                  16'($urandom));
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      repeat (LONG_ITEMS) send_stamp(pick_stamp(1'b1));
      settle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
